FILE: rtl/core/tpw_pkg.sv
// Shared constants, codes and types for the TLB refill page walker.
// Depends on nothing; used by the top level of the block.
`timescale 1ns / 1ps
package tpw_pkg;
	localparam int TABLE_ENTRIES = 64;
	localparam int FRAME_COUNT   = 64;
	localparam int FIRST_FRAME   = 4096;
	localparam int TLB_SLOTS     = 32;

	localparam int PFN_W  = 20;
	localparam int ASID_W = 8;
	localparam int TIDX_W = $clog2(TABLE_ENTRIES);
	localparam int FIDX_W = $clog2(FRAME_COUNT);
	localparam int SLOT_W = $clog2(TLB_SLOTS);
	localparam int SCAN_N = (TABLE_ENTRIES > FRAME_COUNT) ? TABLE_ENTRIES : FRAME_COUNT;
	localparam int CNT_W  = $clog2(SCAN_N + 1);

	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_ALLOC    = 3'd1;
	localparam logic [2:0] ST_ASID     = 3'd2;
	localparam logic [2:0] ST_NO_TABLE = 3'd3;
	localparam logic [2:0] ST_NO_FRAME = 3'd4;

	localparam logic [5:0] LO_CTRL = 6'h16;

	typedef struct packed {
		logic [PFN_W-1:0]  vpn;
		logic [PFN_W-1:0]  frame;
		logic [ASID_W-1:0] owner;
	} tpw_entry_t;
endpackage

FILE: rtl/core/tlb_refill_page_walker_top.sv
// Top level of the TLB refill page walker: sequencer, scan and result register.
// Depends on tpw_pkg and tpw_ram.
`timescale 1ns / 1ps
// Usage
// Each input transaction describes one TLB miss (bad_vaddr, entry_hi_in, probe_missed)
// and produces exactly one output transaction on the result channel. Both channels
// use valid/ready; a transaction completes on a clock edge where both are high.
// The process id is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce. An asid
// mismatch goes from idle straight to the done state. Otherwise one compare unit
// walks the page table and the free lists one index per cycle, a rate set by the
// single read port of the table memory; an allocation adds the write states S_WR0
// and S_WR1, one per entry of the pair. The block accepts one miss at a time.
// The result sits in an output register: in_ready rises again as soon as the
// result is loaded, so a new miss may start while the receiver stalls; if the
// next result is ready before the old one is taken, the sequencer waits.
// Reset clears the valid and frame-used flags, the slot pointer and the process id;
// the table memory itself needs no clearing because every read is qualified by
// its valid flag.
module tlb_refill_page_walker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] bad_vaddr,
	input  logic [31:0] entry_hi_in,
	input  logic        probe_missed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] entry_lo_even,
	output logic [31:0] entry_lo_odd,
	output logic [31:0] entry_hi_out,
	output logic        set_slot,
	output logic [4:0]  tlb_slot
);
	import tpw_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_WR0  = 3'd2;
	localparam logic [2:0] S_WR1  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]               state_q;
	logic [7:0]               pid_q;
	logic [PFN_W-1:0]         pair_q;
	logic [31:0]              hi_q;
	logic                     missed_q;
	logic                     asid_err_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     rd_s1;
	logic [TIDX_W-1:0]        idx_s1;
	logic                     hit_q;
	logic [PFN_W-1:0]         pfn_q;
	logic                     tfound_q;
	logic [TIDX_W-1:0]        tidx_q;
	logic                     ffound_q;
	logic [FIDX_W-1:0]        fidx_q;
	logic [TABLE_ENTRIES-1:0] entry_valid_q;
	logic [FRAME_COUNT-1:0]   frame_used_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [2:0]               res_status;

	// Table memory: one write port for allocation, one read port for the scan.
	logic              ram_we;
	logic [TIDX_W-1:0] ram_waddr;
	tpw_entry_t        ram_wdata;
	tpw_entry_t        ram_rdata;

	tpw_ram #(
		.WIDTH($bits(tpw_entry_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q[TIDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// Per-index checks made while the counter sweeps the table and frame flags.
	logic [CNT_W-1:0] cnt_nx;
	logic             scan_live;
	logic             t_pair_free;
	logic             f_pair_free;
	logic             match_s1;
	logic             scan_end;
	logic [PFN_W-1:0] alloc_pfn;
	logic [SLOT_W-1:0] slot_nx;
	logic             finish;

	assign cnt_nx    = cnt_q + CNT_W'(1);
	assign scan_live = (state_q == S_SCAN) && (cnt_q < CNT_W'(SCAN_N));
	assign t_pair_free = scan_live && !cnt_q[0] && (cnt_nx < CNT_W'(TABLE_ENTRIES + 1))
		&& (cnt_nx < CNT_W'(TABLE_ENTRIES))
		&& !entry_valid_q[cnt_q[TIDX_W-1:0]] && !entry_valid_q[cnt_nx[TIDX_W-1:0]];
	assign f_pair_free = scan_live && !cnt_q[0] && (cnt_nx < CNT_W'(FRAME_COUNT))
		&& !frame_used_q[cnt_q[FIDX_W-1:0]] && !frame_used_q[cnt_nx[FIDX_W-1:0]];
	assign match_s1 = rd_s1 && entry_valid_q[idx_s1] && (ram_rdata.vpn == pair_q)
		&& (ram_rdata.owner == pid_q);
	assign scan_end  = (state_q == S_SCAN) && !scan_live && !rd_s1;
	assign alloc_pfn = PFN_W'(fidx_q) + PFN_W'(FIRST_FRAME);
	assign slot_nx   = (slot_q == SLOT_W'(TLB_SLOTS - 1)) ? '0 : slot_q + SLOT_W'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tidx_q;
		ram_wdata = '{vpn: pair_q, frame: pfn_q, owner: pid_q};
		case (state_q)
			S_WR0: begin
				ram_we = 1'b1;
			end
			S_WR1: begin
				ram_we    = 1'b1;
				ram_waddr = tidx_q + TIDX_W'(1);
				ram_wdata = '{vpn: pair_q + PFN_W'(1), frame: pfn_q + PFN_W'(1), owner: pid_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Result status decided at the end of the scan.
	always_comb begin
		if (asid_err_q) begin
			res_status = ST_ASID;
		end else if (hit_q) begin
			res_status = ST_HIT;
		end else if (!tfound_q) begin
			res_status = ST_NO_TABLE;
		end else if (!ffound_q) begin
			res_status = ST_NO_FRAME;
		end else begin
			res_status = ST_ALLOC;
		end
	end

	// A result can be loaded when the output register is empty or being emptied.
	assign finish   = (state_q == S_DONE) && (!out_valid || out_ready);
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pid_q         <= '0;
			entry_valid_q <= '0;
			frame_used_q  <= '0;
			slot_q        <= '0;
			out_valid     <= 1'b0;
			rd_s1         <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (cfg_wr_en) begin
				pid_q <= cfg_wr_data;
			end
			// A new result takes precedence over the one being handed over.
			if (finish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			rd_s1 <= scan_live && (cnt_q < CNT_W'(TABLE_ENTRIES));
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= (entry_hi_in[7:0] != pid_q && entry_hi_in[7:0] != 8'd0)
							? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_live) begin
						cnt_q <= cnt_nx;
					end
					if (scan_end) begin
						state_q <= (res_status == ST_ALLOC) ? S_WR0 : S_DONE;
					end
				end
				S_WR0: begin
					state_q <= S_WR1;
					entry_valid_q[tidx_q] <= 1'b1;
					frame_used_q[fidx_q]  <= 1'b1;
				end
				S_WR1: begin
					state_q <= S_DONE;
					entry_valid_q[tidx_q + TIDX_W'(1)] <= 1'b1;
					frame_used_q[fidx_q + FIDX_W'(1)]  <= 1'b1;
				end
				S_DONE: begin
					if (finish) begin
						state_q <= S_IDLE;
						if (missed_q && (res_status == ST_HIT || res_status == ST_ALLOC)) begin
							slot_q <= slot_nx;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Work registers of the current miss and scan results.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[TIDX_W-1:0];
		if (state_q == S_IDLE && in_valid) begin
			pair_q     <= {bad_vaddr[31:13], 1'b0};
			hi_q       <= entry_hi_in;
			missed_q   <= probe_missed;
			asid_err_q <= entry_hi_in[7:0] != pid_q && entry_hi_in[7:0] != 8'd0;
			hit_q      <= 1'b0;
			tfound_q   <= 1'b0;
			ffound_q   <= 1'b0;
		end
		if (state_q == S_SCAN) begin
			if (match_s1 && !hit_q) begin
				hit_q <= 1'b1;
				pfn_q <= ram_rdata.frame;
			end
			if (t_pair_free && !tfound_q) begin
				tfound_q <= 1'b1;
				tidx_q   <= cnt_q[TIDX_W-1:0];
			end
			if (f_pair_free && !ffound_q) begin
				ffound_q <= 1'b1;
				fidx_q   <= cnt_q[FIDX_W-1:0];
			end
			if (scan_end && !hit_q) begin
				pfn_q <= alloc_pfn;
			end
		end
		if (finish) begin
			status <= res_status;
			if (res_status == ST_HIT || res_status == ST_ALLOC) begin
				entry_lo_even <= {6'd0, pfn_q, LO_CTRL};
				entry_lo_odd  <= {5'd0, {1'b0, pfn_q} + 21'd1, LO_CTRL};
				entry_hi_out  <= {hi_q[31:13], 5'd0, pid_q};
				set_slot      <= missed_q;
				tlb_slot      <= missed_q ? 5'(slot_nx) : 5'd0;
			end else begin
				entry_lo_even <= '0;
				entry_lo_odd  <= '0;
				entry_hi_out  <= '0;
				set_slot      <= 1'b0;
				tlb_slot      <= '0;
			end
		end
	end

	// An allocation marks exactly one pair of table entries valid over its write states S_WR0 and S_WR1.
	a_pair_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR0 |=> ##1
		$countones(entry_valid_q) == $past($countones(entry_valid_q), 2) + 2)
		else $error("allocation did not validate a pair of entries");

	// Error results carry no entry words.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ASID || status == ST_NO_TABLE || status == ST_NO_FRAME)
		|-> entry_lo_even == 32'd0 && entry_hi_out == 32'd0 && !set_slot)
		else $error("error result carries payload");

	// A miss being worked on blocks further input.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second miss accepted while busy");
endmodule

FILE: rtl/core/tpw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
module tpw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
